// ===== hw/rtl/hcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_pkg: shared types, widths and helpers for the hexagon cell locator
// Pipeline stage records, register indexes and signed rounding helpers.
// ----------------------------------------------------------------------------
package hcl_pkg;

   localparam int GW   = 24;  // geometry register width
   localparam int PXW  = 33;  // point relative to the map center
   localparam int MAGW = 33;  // magnitude of a rounded column or row estimate
   localparam int CW   = 36;  // signed column / row value
   localparam int YW   = 38;  // doubled row index with odd-column offset
   localparam int PW   = 64;  // cell center product
   localparam int EW   = 66;  // center-to-point distance
   localparam int DIV_STEP = 4;  // quotient bits per divider stage

   localparam logic [2:0] REG_CENTER_X    = 3'd0;
   localparam logic [2:0] REG_CENTER_Y    = 3'd1;
   localparam logic [2:0] REG_HALF_SIDE   = 3'd2;
   localparam logic [2:0] REG_HALF_HEIGHT = 3'd3;
   localparam logic [2:0] REG_COL_PITCH   = 3'd4;
   localparam logic [2:0] REG_ROW_PITCH   = 3'd5;

   typedef struct packed {
      logic signed [CW-1:0]  col;
      logic signed [CW-1:0]  row0e;
      logic signed [CW-1:0]  row0o;
      logic                  step_up;
      logic signed [PXW-1:0] px;
      logic signed [PXW-1:0] py;
   } cand_s1_type;

   typedef struct packed {
      logic signed [CW-1:0]  col;
      logic signed [CW-1:0]  col_alt;
      logic signed [CW-1:0]  row;
      logic signed [CW-1:0]  row0e;
      logic signed [CW-1:0]  row0o;
      logic signed [PXW-1:0] px;
      logic signed [PXW-1:0] py;
   } cand_s2_type;

   typedef struct packed {
      logic signed [CW-1:0] col;
      logic signed [CW-1:0] row;
      logic signed [CW-1:0] col_alt;
      logic signed [CW-1:0] row_alt;
   } cell_type;

   typedef struct packed {
      cell_type              tile;
      logic signed [CW-1:0]  yy;
      logic signed [PXW-1:0] px;
      logic signed [PXW-1:0] py;
   } cand_s3_type;

   typedef struct packed {
      cell_type              tile;
      logic signed [YW-1:0]  ym;
      logic                  odd;
      logic signed [PXW-1:0] px;
      logic signed [PXW-1:0] py;
   } cand_s4_type;

   typedef struct packed {
      cell_type              tile;
      logic signed [PW-1:0]  cx;
      logic signed [PW-1:0]  cy;
      logic                  odd;
      logic signed [PXW-1:0] px;
      logic signed [PXW-1:0] py;
   } cand_s5_type;

   typedef struct packed {
      cell_type             tile;
      logic signed [EW-1:0] ex;
      logic signed [EW-1:0] ey;
   } cand_s7_type;

   typedef struct packed {
      cell_type      tile;
      logic [EW-1:0] dx;
      logic [EW-1:0] dy;
      logic          cy_gt;
   } cand_s8_type;

   typedef struct packed {
      cell_type      tile;
      logic          cy_gt;
      logic          side;
      logic          kill;
      logic          dy_le;
      logic          dy_lt;
      logic [GW-1:0] dy_low;
   } edge_ctx_type;

   typedef struct packed {
      edge_ctx_type  ctx;
      logic [GW-1:0] d;
   } edge_in_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [17:0] z;
   } result_type;

   // signed halving, truncated toward zero
   function automatic logic signed [CW-1:0] div2t(input logic signed [CW-1:0] v);
      logic signed [CW-1:0] s;
      s = v[CW-1] ? v + CW'(1) : v;
      return s >>> 1;
   endfunction

   // column-dependent row offset of the offset-to-cube mapping
   function automatic logic signed [CW-1:0] row_adj(input logic signed [CW-1:0] c,
                                                   input logic xpos);
      logic signed [CW-1:0] a;
      a = xpos ? div2t(c + CW'(1)) : div2t(c);
      return a;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
      logic signed [15:0] r;
      if (v > CW'(32767)) begin
         r = 16'sh7FFF;
      end else if (v < -CW'(32768)) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/hex_cell_locate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_cell_locate: flat-topped hexagon cell locator, cube coordinates out
// Depth: set mostly by the 4-bit-per-stage x, y and edge dividers.
// Throughput: one point per cycle while req_stall is low;
//   a two-entry output buffer absorbs stalls.
// Reset: synchronous, clears the pipeline and buffer, loads default geometry.
// ----------------------------------------------------------------------------
module hex_cell_locate import hcl_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_cell_x,
   output logic signed [15:0] rsp_cell_y,
   output logic signed [17:0] rsp_cell_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int QW = 32 + FRAC_BITS;

   logic signed [31:0] center_x_ff, center_y_ff;
   logic [GW-1:0] half_side_ff, half_height_ff, col_pitch_ff, row_pitch_ff;
   logic [GW-1:0] hs, hh, cp, rp;

   logic                  adv;
   logic                  in_valid_ff;
   logic signed [PXW-1:0] px_ff, py_ff;
   logic [PXW-1:0]        px_abs, py_abs;

   logic                  dx_valid;
   logic [QW-1:0]         qx, qy;
   logic signed [PXW-1:0] dpx, dpy;

   logic        cand_valid;
   edge_in_type cand_item;
   logic        res_valid;
   result_type  res;

   result_type buf_mem [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff    <= '0;
         center_y_ff    <= '0;
         half_side_ff   <= 24'd4096;
         half_height_ff <= 24'd7094;
         col_pitch_ff   <= 24'd12288;
         row_pitch_ff   <= 24'd14189;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_CENTER_X:    center_x_ff    <= csr_wdata;
            REG_CENTER_Y:    center_y_ff    <= csr_wdata;
            REG_HALF_SIDE:   half_side_ff   <= csr_wdata[GW-1:0];
            REG_HALF_HEIGHT: half_height_ff <= csr_wdata[GW-1:0];
            REG_COL_PITCH:   col_pitch_ff   <= csr_wdata[GW-1:0];
            REG_ROW_PITCH:   row_pitch_ff   <= csr_wdata[GW-1:0];
            default: ;
         endcase
      end
   end

   // a zero geometry value acts as one
   assign hs = (half_side_ff == '0)   ? GW'(1) : half_side_ff;
   assign hh = (half_height_ff == '0) ? GW'(1) : half_height_ff;
   assign cp = (col_pitch_ff == '0)   ? GW'(1) : col_pitch_ff;
   assign rp = (row_pitch_ff == '0)   ? GW'(1) : row_pitch_ff;

   // hold the whole pipeline only when the last stage cannot drain
   assign adv       = !(res_valid && (count_ff == 2'd2));
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff <= PXW'(req_point_x) - PXW'(center_x_ff);
         py_ff <= PXW'(req_point_y) - PXW'(center_y_ff);
      end
   end

   assign px_abs = px_ff[PXW-1] ? -px_ff : px_ff;
   assign py_abs = py_ff[PXW-1] ? -py_ff : py_ff;

   hcl_div #(
      .NUM_W  (QW),
      .DEN_W  (GW),
      .STEP_W (DIV_STEP),
      .SIDE_W (PXW)
   ) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_valid_ff),
      .in_num    (QW'(px_abs[31:0]) << FRAC_BITS),
      .in_den    (cp),
      .in_side   (px_ff),
      .out_valid (dx_valid),
      .out_quo   (qx),
      .out_side  (dpx)
   );

   hcl_div #(
      .NUM_W  (QW),
      .DEN_W  (GW),
      .STEP_W (DIV_STEP),
      .SIDE_W (PXW)
   ) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (in_valid_ff),
      .in_num    (QW'(py_abs[31:0]) << FRAC_BITS),
      .in_den    (rp),
      .in_side   (py_ff),
      .out_valid (),
      .out_quo   (qy),
      .out_side  (dpy)
   );

   hcl_cand #(
      .FRAC_BITS (FRAC_BITS)
   ) u_cand (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (dx_valid),
      .in_qx       (qx),
      .in_qy       (qy),
      .in_px       (dpx),
      .in_py       (dpy),
      .col_pitch   (cp),
      .row_pitch   (rp),
      .half_side   (hs),
      .half_height (hh),
      .out_valid   (cand_valid),
      .out_item    (cand_item)
   );

   hcl_edge u_edge (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (cand_valid),
      .in_item     (cand_item),
      .half_side   (hs),
      .half_height (hh),
      .out_valid   (res_valid),
      .out_res     (res)
   );

   assign push = res_valid && adv;
   assign pop  = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         buf_mem[wr_ptr_ff] <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   assign rsp_valid  = (count_ff != 2'd0);
   assign rsp_cell_x = buf_mem[rd_ptr_ff].x;
   assign rsp_cell_y = buf_mem[rd_ptr_ff].y;
   assign rsp_cell_z = buf_mem[rd_ptr_ff].z;

endmodule

// ===== hw/rtl/hcl_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_div: pipelined unsigned restoring divider
// Retires STEP_W quotient bits per stage and carries a sideband record along.
// ----------------------------------------------------------------------------
module hcl_div #(
   parameter int NUM_W  = 40,
   parameter int DEN_W  = 24,
   parameter int STEP_W = 4,
   parameter int SIDE_W = 33
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STAGES = (NUM_W + STEP_W - 1) / STEP_W;
   localparam int PAD_W  = STAGES * STEP_W;

   logic [PAD_W-1:0]  acc_ff   [STAGES];
   logic [DEN_W-1:0]  rem_ff   [STAGES];
   logic [SIDE_W-1:0] side_ff  [STAGES];
   logic              valid_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [PAD_W-1:0]  src_acc;
      logic [DEN_W-1:0]  src_rem;
      logic [SIDE_W-1:0] src_side;
      logic              src_valid;
      logic [PAD_W-1:0]  acc_in;
      logic [DEN_W-1:0]  rem_in;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;

      if (s == 0) begin : g_first
         assign src_acc   = PAD_W'(in_num);
         assign src_rem   = '0;
         assign src_side  = in_side;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src_acc   = acc_ff[s-1];
         assign src_rem   = rem_ff[s-1];
         assign src_side  = side_ff[s-1];
         assign src_valid = valid_ff[s-1];
      end

      // shift the next dividend bit into the remainder, quotient bit into the LSB
      always_comb begin
         acc_in = src_acc;
         rem_in = src_rem;
         trial  = '0;
         diff   = '0;
         for (int k = 0; k < STEP_W; k++) begin
            trial = {rem_in, acc_in[PAD_W-1]};
            diff  = trial - {1'b0, in_den};
            if (trial >= {1'b0, in_den}) begin
               rem_in = diff[DEN_W-1:0];
               acc_in = {acc_in[PAD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DEN_W-1:0];
               acc_in = {acc_in[PAD_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            acc_ff[s]  <= acc_in;
            rem_ff[s]  <= rem_in;
            side_ff[s] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo   = acc_ff[STAGES-1][NUM_W-1:0];
   assign out_side  = side_ff[STAGES-1];

endmodule

// ===== hw/rtl/hcl_cand.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_cand: candidate cell and center distance
// Rounds column and row, rebuilds the cell center and measures the distance.
// ----------------------------------------------------------------------------
module hcl_cand import hcl_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [31+FRAC_BITS:0] in_qx,
   input  logic [31+FRAC_BITS:0] in_qy,
   input  logic signed [PXW-1:0] in_px,
   input  logic signed [PXW-1:0] in_py,
   input  logic [GW-1:0]         col_pitch,
   input  logic [GW-1:0]         row_pitch,
   input  logic [GW-1:0]         half_side,
   input  logic [GW-1:0]         half_height,
   output logic                  out_valid,
   output edge_in_type           out_item
);

   localparam int QW  = 32 + FRAC_BITS;
   localparam int ONE = 1 << FRAC_BITS;
   localparam int HALF = ONE >> 1;
   localparam logic [QW:0] HALF_Q = (QW+1)'(HALF);
   localparam logic [QW:0] FMASK  = (QW+1)'(ONE - 1);

   logic [9:1] v_ff;

   cand_s1_type s1_in, s1_ff;
   cand_s2_type s2_in, s2_ff;
   cand_s3_type s3_in, s3_ff;
   cand_s4_type s4_in, s4_ff;
   cand_s5_type s5_in, s5_ff;
   cand_s5_type s6_in, s6_ff;
   cand_s7_type s7_in, s7_ff;
   cand_s8_type s8_in, s8_ff;
   edge_in_type s9_in, s9_ff;

   logic [QW:0] colq_mag;
   logic [QW:0] yrnd;
   logic [QW:0] frac;
   logic        xpos;
   logic        ypos;

   // column rounded half away from zero, row estimates for both parities
   always_comb begin
      xpos     = !in_px[PXW-1];
      ypos     = !in_py[PXW-1];
      colq_mag = {1'b0, in_qx} + HALF_Q;
      yrnd     = {1'b0, in_qy} + HALF_Q;
      frac     = colq_mag & FMASK;
      s1_in.col = xpos ? $signed(CW'(colq_mag[FRAC_BITS +: MAGW]))
                       : -$signed(CW'(colq_mag[FRAC_BITS +: MAGW]));
      s1_in.step_up = xpos ? (frac > HALF_Q) : (frac < HALF_Q);
      s1_in.row0e = ypos ? $signed(CW'(yrnd[FRAC_BITS +: MAGW]))
                         : -$signed(CW'(yrnd[FRAC_BITS +: MAGW]));
      s1_in.row0o = ypos ? $signed(CW'(in_qy[FRAC_BITS +: 32])) + CW'(1)
                         : -$signed(CW'(in_qy[FRAC_BITS +: 32]));
      s1_in.px = in_px;
      s1_in.py = in_py;
   end

   always_comb begin
      s2_in.col     = s1_ff.col;
      s2_in.col_alt = s1_ff.step_up ? s1_ff.col + CW'(1) : s1_ff.col - CW'(1);
      s2_in.row     = (s1_ff.col[0] ? s1_ff.row0o : s1_ff.row0e)
                      - row_adj(s1_ff.col, !s1_ff.px[PXW-1]);
      s2_in.row0e   = s1_ff.row0e;
      s2_in.row0o   = s1_ff.row0o;
      s2_in.px      = s1_ff.px;
      s2_in.py      = s1_ff.py;
   end

   always_comb begin
      s3_in.tile.col     = s2_ff.col;
      s3_in.tile.row     = s2_ff.row;
      s3_in.tile.col_alt = s2_ff.col_alt;
      s3_in.tile.row_alt = (s2_ff.col_alt[0] ? s2_ff.row0o : s2_ff.row0e)
                           - row_adj(s2_ff.col_alt, !s2_ff.px[PXW-1]);
      s3_in.yy = s2_ff.row + s2_ff.col - div2t(s2_ff.col);
      s3_in.px = s2_ff.px;
      s3_in.py = s2_ff.py;
   end

   // odd columns sit half a row off: build 2y -+ 1 for the center product
   always_comb begin
      s4_in.tile = s3_ff.tile;
      s4_in.odd  = s3_ff.tile.col[0];
      if (!s3_ff.tile.col[0]) begin
         s4_in.ym = YW'(s3_ff.yy);
      end else if (!s3_ff.tile.col[CW-1]) begin
         s4_in.ym = (YW'(s3_ff.yy) <<< 1) - YW'(1);
      end else begin
         s4_in.ym = (YW'(s3_ff.yy) <<< 1) + YW'(1);
      end
      s4_in.px = s3_ff.px;
      s4_in.py = s3_ff.py;
   end

   always_comb begin
      s5_in.tile = s4_ff.tile;
      s5_in.cx   = PW'(s4_ff.tile.col) * PW'($signed({1'b0, col_pitch}));
      s5_in.cy   = PW'(s4_ff.ym) * PW'($signed({1'b0, row_pitch}));
      s5_in.odd  = s4_ff.odd;
      s5_in.px   = s4_ff.px;
      s5_in.py   = s4_ff.py;
   end

   logic signed [PW-1:0] cy_bias;

   always_comb begin
      cy_bias  = s5_ff.cy[PW-1] ? s5_ff.cy + PW'(1) : s5_ff.cy;
      s6_in    = s5_ff;
      s6_in.cy = s5_ff.odd ? (cy_bias >>> 1) : s5_ff.cy;
   end

   always_comb begin
      s7_in.tile = s6_ff.tile;
      s7_in.ex   = EW'(s6_ff.cx) - EW'(s6_ff.px);
      s7_in.ey   = EW'(s6_ff.cy) - EW'(s6_ff.py);
   end

   always_comb begin
      s8_in.tile  = s7_ff.tile;
      s8_in.dx    = s7_ff.ex[EW-1] ? -s7_ff.ex : s7_ff.ex;
      s8_in.dy    = s7_ff.ey[EW-1] ? -s7_ff.ey : s7_ff.ey;
      s8_in.cy_gt = !s7_ff.ey[EW-1] && (s7_ff.ey != '0);
   end

   // at or beyond twice the half side the slanted edge rejects the point outright
   always_comb begin
      s9_in.ctx.tile   = s8_ff.tile;
      s9_in.ctx.cy_gt  = s8_ff.cy_gt;
      s9_in.ctx.side   = s8_ff.dx > EW'(half_side);
      s9_in.ctx.kill   = s8_ff.dx >= EW'({half_side, 1'b0});
      s9_in.ctx.dy_le  = s8_ff.dy <= EW'(half_height);
      s9_in.ctx.dy_lt  = s8_ff.dy < EW'(half_height);
      s9_in.ctx.dy_low = s8_ff.dy[GW-1:0];
      s9_in.d          = GW'(s8_ff.dx - EW'(half_side));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[8:1], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
         s9_ff <= s9_in;
      end
   end

   assign out_valid = v_ff[9];
   assign out_item  = s9_ff;

endmodule

// ===== hw/rtl/hcl_edge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcl_edge: hexagon edge test and cell correction
// Tests the slanted edge, moves the candidate by one on a miss, saturates.
// ----------------------------------------------------------------------------
module hcl_edge import hcl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  logic          in_valid,
   input  edge_in_type   in_item,
   input  logic [GW-1:0] half_side,
   input  logic [GW-1:0] half_height,
   output logic          out_valid,
   output result_type    out_res
);

   localparam int SIDE_W = $bits(edge_ctx_type);

   logic [2*GW-1:0] prod_ff;
   edge_ctx_type    ctx1_ff;
   logic            v1_ff;

   logic              dv;
   logic [2*GW-1:0]   quo;
   logic [SIDE_W-1:0] dside;
   edge_ctx_type      dctx;

   logic         hit_in, hit_ff;
   edge_ctx_type ctx2_ff;
   logic         v2_ff;

   logic signed [CW-1:0] col_in, row_in, col_ff, row_ff;
   logic                 v3_ff;

   result_type res_in, res_ff;
   logic       v4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= (2*GW)'(half_height) * (2*GW)'(in_item.d);
         ctx1_ff <= in_item.ctx;
      end
   end

   hcl_div #(
      .NUM_W  (2*GW),
      .DEN_W  (GW),
      .STEP_W (DIV_STEP),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v1_ff),
      .in_num    (prod_ff),
      .in_den    (half_side),
      .in_side   (ctx1_ff),
      .out_valid (dv),
      .out_quo   (quo),
      .out_side  (dside)
   );

   assign dctx = dside;

   always_comb begin
      if (dctx.side) begin
         hit_in = !dctx.kill && dctx.dy_lt
                  && (({1'b0, dctx.dy_low} + {1'b0, quo[GW-1:0]}) < {1'b0, half_height});
      end else begin
         hit_in = dctx.dy_le;
      end
   end

   // on a miss step across the slanted edge or up/down to the next row
   always_comb begin
      if (hit_ff) begin
         col_in = ctx2_ff.tile.col;
         row_in = ctx2_ff.tile.row;
      end else if (ctx2_ff.side) begin
         col_in = ctx2_ff.tile.col_alt;
         row_in = ctx2_ff.tile.row_alt;
      end else begin
         col_in = ctx2_ff.tile.col;
         row_in = ctx2_ff.cy_gt ? ctx2_ff.tile.row - CW'(1) : ctx2_ff.tile.row + CW'(1);
      end
   end

   always_comb begin
      res_in.x = sat16(col_ff);
      res_in.y = sat16(row_ff);
      res_in.z = -(18'(res_in.x) + 18'(res_in.y));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= dv;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= hit_in;
         ctx2_ff <= dctx;
         col_ff  <= col_in;
         row_ff  <= row_in;
         res_ff  <= res_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_res   = res_ff;

endmodule

// ===== bench/hex_cell_locate_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_cell_locate_test: self-checking bench for the hexagon cell locator
// Walks a directed table of points under reset, zero and extreme geometry,
// then random points under random map settings with varied idling on both
// channels. Each response is compared with a typed value or an in-bench cell predictor.
// ----------------------------------------------------------------------------
module hex_cell_locate_test import hcl_pkg::*; ();

   localparam longint ONE   = 256;
   localparam longint HALF  = 128;
   localparam int     LIMIT = 600000;
   localparam logic [2:0] REG_SPARE_6 = 3'd6;
   localparam logic [2:0] REG_SPARE_7 = 3'd7;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      bit                 typed;
      result_type         due;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_point_x = '0;
   logic signed [31:0] req_point_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_cell_x;
   logic signed [15:0] rsp_cell_y;
   logic signed [17:0] rsp_cell_z;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // shadow of the map settings
   logic signed [31:0] map_cx, map_cy;
   logic [23:0] geo_hs, geo_hh, geo_cp, geo_rp;

   result_type cells_due[$];
   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;

   hex_cell_locate u_dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cells_due.size() == 0) begin
            report_mismatch("unexpected transfer, cell_x", rsp_cell_x, 0);
         end else begin
            want = cells_due.pop_front();
            if (rsp_cell_x !== want.x) report_mismatch("cell_x", rsp_cell_x, want.x);
            if (rsp_cell_y !== want.y) report_mismatch("cell_y", rsp_cell_y, want.y);
            if (rsp_cell_z !== want.z) report_mismatch("cell_z", rsp_cell_z, want.z);
         end
      end
   end

   function automatic longint nonzero(input logic [23:0] v);
      return (v == 0) ? 1 : longint'(v);
   endfunction

   function automatic longint clamp16(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint row_guess(input longint col, input longint px,
                                        input longint py, input longint rp);
      longint r;
      r = py * ONE / rp;
      if (col[0] == 1'b0) r += (py >= 0) ? HALF : -HALF;
      else r += (py >= 0) ? ONE : 0;
      return r / ONE - ((px >= 0) ? (col + 1) / 2 : col / 2);
   endfunction

   function automatic result_type locate_cell(input logic signed [31:0] x,
                                              input logic signed [31:0] y);
      longint px, py, cp, rp, hs, hh, colq, col, row, yy, cx, cy, dx, dy, edge_q, sx, sy;
      bit side, hit;
      result_type res;
      px = longint'(x) - longint'(map_cx);
      py = longint'(y) - longint'(map_cy);
      cp = nonzero(geo_cp);
      rp = nonzero(geo_rp);
      hs = nonzero(geo_hs);
      hh = nonzero(geo_hh);
      colq = px * ONE / cp + ((px >= 0) ? HALF : -HALF);
      col = colq / ONE;
      row = row_guess(col, px, py, rp);
      yy = row + col - col / 2;
      cx = col * cp;
      if (col[0] == 1'b0) cy = yy * rp;
      else if (col >= 0) cy = (2 * yy - 1) * rp / 2;
      else cy = (2 * yy + 1) * rp / 2;
      dx = (cx > px) ? cx - px : px - cx;
      dy = (cy > py) ? cy - py : py - cy;
      side = (dx > hs);
      hit = side ? (dy < hh - hh * (dx - hs) / hs) : (dy <= hh);
      if (!hit) begin
         if (side) begin
            edge_q = col * ONE + ((px >= 0) ? HALF : -HALF);
            col += (colq > edge_q) ? 1 : -1;
            row = row_guess(col, px, py, rp);
         end else begin
            row += (cy > py) ? -1 : 1;
         end
      end
      sx = clamp16(col);
      sy = clamp16(row);
      res.x = sx[15:0];
      res.y = sy[15:0];
      res.z = 18'(-(sx + sy));
      return res;
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_CENTER_X:    map_cx = data;
         REG_CENTER_Y:    map_cy = data;
         REG_HALF_SIDE:   geo_hs = data[23:0];
         REG_HALF_HEIGHT: geo_hh = data[23:0];
         REG_COL_PITCH:   geo_cp = data[23:0];
         REG_ROW_PITCH:   geo_rp = data[23:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // registers change only with the pipeline drained
   task automatic drain;
      req_valid <= 1'b0;
      wait (cells_due.size() == 0);
      repeat (50) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
                             input bit typed, input result_type due);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_point_x <= x;
      req_point_y <= y;
      do @(posedge clock); while (req_stall);
      cells_due.insert(cells_due.size(), typed ? due : locate_cell(x, y));
      @(negedge clock);
   endtask

   task automatic random_map;
      write_reg(REG_CENTER_X, $urandom());
      write_reg(REG_CENTER_Y, $urandom());
      write_reg(REG_HALF_SIDE,
                {8'($urandom_range(255)), 8'd0, 16'($urandom_range(9000))});
      write_reg(REG_HALF_HEIGHT,
                {8'($urandom_range(255)), 8'd0, 16'($urandom_range(16000))});
      write_reg(REG_COL_PITCH,
                {8'($urandom_range(255)), 8'd0, 16'($urandom_range(1, 20000))});
      write_reg(REG_ROW_PITCH,
                {8'($urandom_range(255)), 8'd0, 16'($urandom_range(1, 20000))});
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
   endtask

   point_row_type points[8] = '{
      '{32'sd0, 32'sd0, 1'b1, '{16'sd0, 16'sd0, 18'sd0}},
      '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, '{0, 0, 0}},
      '{32'sh80000000, 32'sh80000000, 1'b0, '{0, 0, 0}},
      '{32'sh7FFFFFFF, 32'sh80000000, 1'b0, '{0, 0, 0}},
      '{32'sh80000000, 32'sh7FFFFFFF, 1'b0, '{0, 0, 0}},
      '{32'sd6144, 32'sd7094, 1'b0, '{0, 0, 0}},
      '{-32'sd6144, -32'sd7095, 1'b0, '{0, 0, 0}},
      '{32'sd4097, -32'sd1, 1'b0, '{0, 0, 0}}
   };

   initial begin
      result_type none;
      logic signed [31:0] x, y;
      none = '0;
      map_cx = 0; map_cy = 0;
      geo_hs = 24'd4096; geo_hh = 24'd7094; geo_cp = 24'd12288; geo_rp = 24'd14189;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset geometry, then zero geometry, then the extremes
      foreach (points[i]) send_point(points[i].x, points[i].y, points[i].typed, points[i].due);
      drain();
      write_reg(REG_HALF_SIDE, 0);
      write_reg(REG_HALF_HEIGHT, 0);
      write_reg(REG_COL_PITCH, 0);
      write_reg(REG_ROW_PITCH, 0);
      write_reg(REG_SPARE_6, 32'hFFFFFFFF);
      foreach (points[i]) send_point(points[i].x, points[i].y, 1'b0, none);
      drain();
      write_reg(REG_CENTER_X, 32'h7FFFFFFF);
      write_reg(REG_CENTER_Y, 32'h80000000);
      write_reg(REG_HALF_SIDE, 32'hFFFFFFFF);
      write_reg(REG_HALF_HEIGHT, 32'h00FFFFFF);
      write_reg(REG_COL_PITCH, 32'h00FFFFFF);
      write_reg(REG_ROW_PITCH, 32'hFFFFFFFF);
      write_reg(REG_SPARE_7, 32'h0);
      foreach (points[i]) send_point(points[i].x, points[i].y, 1'b0, none);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 37 : (phase == 1) ? 74 : 0;
         recv_idle = (phase == 0) ? 74 : (phase == 1) ? 37 : 0;
         for (int k = 0; k < 4; k++) begin
            random_map();
            for (int n = 0; n < 67; n++) begin
               // mostly points near the center, some anywhere
               if ($urandom_range(4) == 0) begin
                  x = $urandom();
                  y = $urandom();
               end else begin
                  x = map_cx + $signed(32'($urandom_range(400000)) - 32'sd200000);
                  y = map_cy + $signed(32'($urandom_range(400000)) - 32'sd200000);
               end
               send_point(x, y, 1'b0, none);
            end
            drain();
         end
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
